[design/chu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package chu_pkg;

   localparam int SAMPLE_W = 16;
   localparam int DIFF_W   = 17;
   localparam int CSR_W    = 3;
   localparam int SEEN_W   = 2;

   localparam logic [CSR_W-1:0]  CSR_RESET = 3'd1;
   localparam logic [SEEN_W-1:0] SEEN_NONE = 2'd0;
   localparam logic [SEEN_W-1:0] SEEN_ONE  = 2'd1;
   localparam logic [SEEN_W-1:0] SEEN_TWO  = 2'd2;
   localparam logic [SEEN_W-1:0] SEEN_MAX  = 2'd3;

   localparam int SAT_HI = 32767;
   localparam int SAT_LO = -32768;

   // which interval of the current sample is being emitted
   typedef enum logic [1:0] {
      SEL_MAIN = 2'd0,
      SEL_TAIL = 2'd1,
      SEL_END  = 2'd2
   } sel_type;

   typedef struct packed {
      logic    capture;
      logic    issue;
      sel_type sel;
      logic    use_d0;
      logic    mark_last;
      logic    shift;
      logic    clear;
   } dp_cmd_type;

endpackage

`default_nettype wire

[design/cubic_hermite_upsampler.sv]
`timescale 1ns / 1ps
`default_nettype none
// each result passes through stage registers 0 to 4 and then the output register
// per sample, R = 0..3 intervals of 2^L phases are emitted, none for some samples; a new
// sample is taken only when the controller is idle again; the 6-stage datapath stalls as a whole
// when the output beat is held, and the controller issues one phase per cycle while the datapath advances
// reset: synchronous, clears sample history and state; upsample_log2 returns to 1

module cubic_hermite_upsampler #(
   parameter int MAX_UPSAMPLE_LOG2 = 4
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [chu_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  wire logic                                 req_last_in,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [chu_pkg::SAMPLE_W-1:0]       rsp_sample_out,
   output logic                                      rsp_last_out,
   input  wire logic                                 csr_wr_en,
   input  wire logic [chu_pkg::CSR_W-1:0]            csr_wr_data
);

   chu_pkg::dp_cmd_type             cmd;
   logic [MAX_UPSAMPLE_LOG2-1:0]    phase;
   logic                            adv;

   chu_ctrl #(
      .MAX_UPSAMPLE_LOG2(MAX_UPSAMPLE_LOG2)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_last_in (req_last_in),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .adv         (adv),
      .cmd         (cmd),
      .phase       (phase)
   );

   chu_datapath #(
      .MAX_UPSAMPLE_LOG2(MAX_UPSAMPLE_LOG2)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .phase          (phase),
      .req_sample_in  (req_sample_in),
      .adv            (adv),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_last_out   (rsp_last_out)
   );

`ifndef SYNTH
   a_issue_needs_adv: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> adv)
      else $error("phase issued while datapath is held");

   a_accept_no_issue: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (!cmd.issue && !cmd.shift && !cmd.clear))
      else $error("beat taken while an interval is in progress");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_last |-> (cmd.clear && cmd.issue && !cmd.shift))
      else $error("final beat not paired with history clear");

   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("controller ready again right after a beat");
`endif

endmodule

`default_nettype wire

[design/chu_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module chu_ctrl #(
   parameter int MAX_UPSAMPLE_LOG2 = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_last_in,
   input  wire logic                       csr_wr_en,
   input  wire logic [chu_pkg::CSR_W-1:0]  csr_wr_data,
   input  wire logic                       adv,
   output chu_pkg::dp_cmd_type             cmd,
   output logic [MAX_UPSAMPLE_LOG2-1:0]    phase
);

   localparam int F = MAX_UPSAMPLE_LOG2;
   localparam logic [chu_pkg::CSR_W-1:0] FMAX = chu_pkg::CSR_W'(F);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MAIN = 5'b00010,
      ST_TAIL = 5'b00100,
      ST_END  = 5'b01000,
      ST_SKIP = 5'b10000
   } state_type;

   state_type                        state_ff, state_in;
   logic [chu_pkg::CSR_W-1:0]        csr_ff, csr_in;
   logic [chu_pkg::SEEN_W-1:0]       seen_ff, seen_in;
   logic                             last_ff, last_in;
   logic [F-1:0]                     u_ff, u_in;

   logic [chu_pkg::CSR_W-1:0]        l_eff;
   logic [chu_pkg::CSR_W-1:0]        shamt;
   logic [F:0]                       step;
   logic [F:0]                       u_next;
   logic                             fin;
   logic                             accept;
   logic [chu_pkg::SEEN_W-1:0]       seen_inc;

   assign l_eff    = (csr_ff > FMAX) ? FMAX : csr_ff;
   assign shamt    = FMAX - l_eff;
   assign step     = (F+1)'(1) << shamt;
   assign u_next   = {1'b0, u_ff} + step;
   assign fin      = u_next[F];
   assign req_stall = (state_ff != ST_IDLE);
   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign phase    = u_ff;
   assign seen_inc = (seen_ff == chu_pkg::SEEN_MAX) ? chu_pkg::SEEN_MAX
                                                     : seen_ff + chu_pkg::SEEN_W'(1);

   always_comb begin
      state_in = state_ff;
      csr_in   = csr_wr_en ? csr_wr_data : csr_ff;
      seen_in  = seen_ff;
      last_in  = last_ff;
      u_in     = u_ff;
      cmd      = '0;
      cmd.sel  = chu_pkg::SEL_MAIN;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = accept;
            if (accept) begin
               last_in = req_last_in;
               u_in    = '0;
               if (seen_ff >= chu_pkg::SEEN_TWO) begin
                  state_in = ST_MAIN;
               end else if (req_last_in) begin
                  state_in = (seen_ff == chu_pkg::SEEN_ONE) ? ST_TAIL : ST_END;
               end else begin
                  state_in = ST_SKIP;
               end
            end
         end
         ST_MAIN: begin
            cmd.issue  = adv;
            cmd.sel    = chu_pkg::SEL_MAIN;
            cmd.use_d0 = (seen_ff == chu_pkg::SEEN_MAX);
            if (adv) begin
               u_in = u_next[F-1:0];
               if (fin) begin
                  u_in = '0;
                  if (last_ff) begin
                     state_in = ST_TAIL;
                  end else begin
                     cmd.shift = 1'b1;
                     seen_in   = seen_inc;
                     state_in  = ST_IDLE;
                  end
               end
            end
         end
         ST_TAIL: begin
            cmd.issue  = adv;
            cmd.sel    = chu_pkg::SEL_TAIL;
            cmd.use_d0 = (seen_ff >= chu_pkg::SEEN_TWO);
            if (adv) begin
               u_in = u_next[F-1:0];
               if (fin) begin
                  u_in     = '0;
                  state_in = ST_END;
               end
            end
         end
         ST_END: begin
            cmd.issue = adv;
            cmd.sel   = chu_pkg::SEL_END;
            if (adv) begin
               u_in = u_next[F-1:0];
               if (fin) begin
                  u_in          = '0;
                  cmd.mark_last = 1'b1;
                  cmd.clear     = 1'b1;
                  seen_in       = chu_pkg::SEEN_NONE;
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_SKIP: begin
            cmd.shift = 1'b1;
            seen_in   = seen_inc;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         csr_ff   <= chu_pkg::CSR_RESET;
         seen_ff  <= chu_pkg::SEEN_NONE;
         last_ff  <= 1'b0;
         u_ff     <= '0;
      end else begin
         state_ff <= state_in;
         csr_ff   <= csr_in;
         seen_ff  <= seen_in;
         last_ff  <= last_in;
         u_ff     <= u_in;
      end
   end

endmodule

`default_nettype wire

[design/chu_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module chu_datapath #(
   parameter int MAX_UPSAMPLE_LOG2 = 4
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire chu_pkg::dp_cmd_type                  cmd,
   input  wire logic [MAX_UPSAMPLE_LOG2-1:0]         phase,
   input  wire logic signed [chu_pkg::SAMPLE_W-1:0]  req_sample_in,
   output logic                                      adv,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [chu_pkg::SAMPLE_W-1:0]       rsp_sample_out,
   output logic                                      rsp_last_out
);

   localparam int F   = MAX_UPSAMPLE_LOG2;
   localparam int SW  = chu_pkg::SAMPLE_W;
   localparam int DW  = chu_pkg::DIFF_W;
   localparam int U2W = 2 * F;
   localparam int U3W = 3 * F;
   localparam int WW  = 3 * F + 2;
   localparam int PW  = WW + DW;
   localparam int TW  = PW + 2;
   localparam int RSH = 3 * F + 1;
   localparam logic signed [WW-1:0] CUBE = WW'(1) <<< (3 * F);
   localparam logic signed [TW-1:0] BIAS = TW'(1) <<< (3 * F);
   localparam logic signed [TW-1:0] HI   = TW'(chu_pkg::SAT_HI);
   localparam logic signed [TW-1:0] LO   = TW'(chu_pkg::SAT_LO);

   // sample history
   logic signed [SW-1:0] x_ff, x_in;
   logic signed [SW-1:0] prev_one_ff, prev_one_in;
   logic signed [SW-1:0] prev_two_ff, prev_two_in;
   logic signed [SW-1:0] prev_three_ff, prev_three_in;

   // operand select
   logic signed [SW-1:0] p0_in, p1_in;
   logic signed [DW-1:0] d0_in, d1_in;

   // stage 0
   logic                 v0_ff, l0_ff;
   logic [F-1:0]         u0_ff;
   logic signed [SW-1:0] p0_0_ff, p1_0_ff;
   logic signed [DW-1:0] d0_0_ff, d1_0_ff;
   // stage 1
   logic                 v1_ff, l1_ff;
   logic [F-1:0]         u1_ff;
   logic [U2W-1:0]       u2_ff, u2_in;
   logic signed [SW-1:0] p0_1_ff, p1_1_ff;
   logic signed [DW-1:0] d0_1_ff, d1_1_ff;
   // stage 2
   logic                 v2_ff, l2_ff;
   logic signed [WW-1:0] h00_ff, h10_ff, h01_ff, h11_ff;
   logic signed [WW-1:0] h00_in, h10_in, h01_in, h11_in;
   logic signed [SW-1:0] p0_2_ff, p1_2_ff;
   logic signed [DW-1:0] d0_2_ff, d1_2_ff;
   // stage 3
   logic                 v3_ff, l3_ff;
   logic signed [PW-1:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [PW-1:0] pa_in, pb_in, pc_in, pd_in;
   // stage 4
   logic                 v4_ff, l4_ff;
   logic signed [TW-1:0] sa_ff, sb_ff, sa_in, sb_in;
   // output
   logic                 rsp_valid_ff, rsp_last_ff;
   logic signed [SW-1:0] rsp_sample_ff, rsp_sample_in;

   logic [U3W-1:0]       u3;
   logic signed [WW-1:0] t3, t2s, t1s;
   logic signed [TW-1:0] tot, rs;

   assign adv            = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_last_out   = rsp_last_ff;

   always_comb begin
      x_in          = cmd.capture ? req_sample_in : x_ff;
      prev_one_in   = prev_one_ff;
      prev_two_in   = prev_two_ff;
      prev_three_in = prev_three_ff;
      if (cmd.clear) begin
         prev_one_in   = '0;
         prev_two_in   = '0;
         prev_three_in = '0;
      end else if (cmd.shift) begin
         prev_one_in   = x_ff;
         prev_two_in   = prev_one_ff;
         prev_three_in = prev_two_ff;
      end
   end

   always_comb begin
      p0_in = '0;
      p1_in = '0;
      d0_in = '0;
      d1_in = '0;
      case (cmd.sel)
         chu_pkg::SEL_MAIN: begin
            p0_in = prev_two_ff;
            p1_in = prev_one_ff;
            d0_in = cmd.use_d0 ? DW'(prev_one_ff) - DW'(prev_three_ff) : '0;
            d1_in = DW'(x_ff) - DW'(prev_two_ff);
         end
         chu_pkg::SEL_TAIL: begin
            p0_in = prev_one_ff;
            p1_in = x_ff;
            d0_in = cmd.use_d0 ? DW'(x_ff) - DW'(prev_two_ff) : '0;
         end
         chu_pkg::SEL_END: begin
            p0_in = x_ff;
         end
         default: begin
            p0_in = '0;
         end
      endcase
   end

   // hermite weights scaled by 2^(3F)
   always_comb begin
      u2_in  = U2W'(u0_ff) * U2W'(u0_ff);
      u3     = U3W'(u2_ff) * U3W'(u1_ff);
      t3     = $signed(WW'(u3));
      t2s    = $signed(WW'({u2_ff, {F{1'b0}}}));
      t1s    = $signed(WW'({u1_ff, {U2W{1'b0}}}));
      h00_in = (t3 <<< 1) - (t2s <<< 1) - t2s + CUBE;
      h10_in = t3 - (t2s <<< 1) + t1s;
      h01_in = (t2s <<< 1) + t2s - (t3 <<< 1);
      h11_in = t3 - t2s;
   end

   always_comb begin
      pa_in = (PW'(h00_ff) * PW'(p0_2_ff)) <<< 1;
      pb_in = PW'(h10_ff) * PW'(d0_2_ff);
      pc_in = (PW'(h01_ff) * PW'(p1_2_ff)) <<< 1;
      pd_in = PW'(h11_ff) * PW'(d1_2_ff);
      sa_in = TW'(pa_ff) + TW'(pb_ff) + BIAS;
      sb_in = TW'(pc_ff) + TW'(pd_ff);
      tot   = sa_ff + sb_ff;
      rs    = tot >>> RSH;
      if (rs > HI) begin
         rsp_sample_in = SW'(HI);
      end else if (rs < LO) begin
         rsp_sample_in = SW'(LO);
      end else begin
         rsp_sample_in = rs[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff          <= '0;
         prev_one_ff   <= '0;
         prev_two_ff   <= '0;
         prev_three_ff <= '0;
      end else begin
         x_ff          <= x_in;
         prev_one_ff   <= prev_one_in;
         prev_two_ff   <= prev_two_in;
         prev_three_ff <= prev_three_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v0_ff        <= cmd.issue;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l0_ff         <= cmd.mark_last;
         u0_ff         <= phase;
         p0_0_ff       <= p0_in;
         p1_0_ff       <= p1_in;
         d0_0_ff       <= d0_in;
         d1_0_ff       <= d1_in;
         l1_ff         <= l0_ff;
         u1_ff         <= u0_ff;
         u2_ff         <= u2_in;
         p0_1_ff       <= p0_0_ff;
         p1_1_ff       <= p1_0_ff;
         d0_1_ff       <= d0_0_ff;
         d1_1_ff       <= d1_0_ff;
         l2_ff         <= l1_ff;
         h00_ff        <= h00_in;
         h10_ff        <= h10_in;
         h01_ff        <= h01_in;
         h11_ff        <= h11_in;
         p0_2_ff       <= p0_1_ff;
         p1_2_ff       <= p1_1_ff;
         d0_2_ff       <= d0_1_ff;
         d1_2_ff       <= d1_1_ff;
         l3_ff         <= l2_ff;
         pa_ff         <= pa_in;
         pb_ff         <= pb_in;
         pc_ff         <= pc_in;
         pd_ff         <= pd_in;
         l4_ff         <= l3_ff;
         sa_ff         <= sa_in;
         sb_ff         <= sb_in;
         rsp_last_ff   <= l4_ff;
         rsp_sample_ff <= rsp_sample_in;
      end
   end

endmodule

`default_nettype wire

[tb/tb_cubic_hermite_upsampler.sv]
`timescale 1ns / 1ps

module tb_cubic_hermite_upsampler;

   localparam int MAX_LOG2  = 4;
   localparam int SUM_SHIFT = 3 * MAX_LOG2 + 1;
   localparam int HALF_LSB  = 1 << (SUM_SHIFT - 1);

   typedef struct packed {
      logic signed [chu_pkg::SAMPLE_W-1:0] sample;
      logic                                last;
   } beat_type;

   class hermite_scoreboard;
      logic [chu_pkg::CSR_W-1:0]           factor_log2;
      logic signed [chu_pkg::SAMPLE_W-1:0] newest;
      logic signed [chu_pkg::SAMPLE_W-1:0] middle;
      logic signed [chu_pkg::SAMPLE_W-1:0] oldest;
      logic [chu_pkg::SEEN_W-1:0]          seen;
      beat_type                            expected_beats[$];
      int                                  failures;
      int                                  samples_noted;
      int                                  traces_closed;
      int                                  beats_checked;

      function new();
         factor_log2   = chu_pkg::CSR_RESET;
         newest        = '0;
         middle        = '0;
         oldest        = '0;
         seen          = chu_pkg::SEEN_NONE;
         failures      = 0;
         samples_noted = 0;
         traces_closed = 0;
         beats_checked = 0;
      endfunction

      function void set_factor(logic [chu_pkg::CSR_W-1:0] value);
         factor_log2 = value;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      // one interval of 2^L phases, weights scaled by 2^(3F), tangents kept doubled
      function void push_interval(longint p0, longint p1, longint d0, longint d1, bit closes);
         int       l;
         int       cnt;
         longint   one;
         longint   u;
         longint   u2;
         longint   u3;
         longint   h00;
         longint   h10;
         longint   h01;
         longint   h11;
         longint   sum;
         longint   r;
         beat_type b;
         l   = (factor_log2 > MAX_LOG2) ? MAX_LOG2 : int'(factor_log2);
         cnt = 1 << l;
         one = longint'(1) << MAX_LOG2;
         for (int k = 0; k < cnt; k++) begin
            u   = longint'(k) << (MAX_LOG2 - l);
            u2  = u * u;
            u3  = u2 * u;
            h00 = 2 * u3 - 3 * u2 * one + one * one * one;
            h10 = u3 - 2 * u2 * one + u * one * one;
            h01 = -2 * u3 + 3 * u2 * one;
            h11 = u3 - u2 * one;
            sum = 2 * h00 * p0 + h10 * d0 + 2 * h01 * p1 + h11 * d1;
            r   = (sum + HALF_LSB) >>> SUM_SHIFT;
            if (r > chu_pkg::SAT_HI) r = chu_pkg::SAT_HI;
            if (r < chu_pkg::SAT_LO) r = chu_pkg::SAT_LO;
            b.sample = r[chu_pkg::SAMPLE_W-1:0];
            b.last   = closes && (k == cnt - 1);
            expected_beats.push_back(b);
         end
      endfunction

      function void note_sample(logic signed [chu_pkg::SAMPLE_W-1:0] s, logic l);
         longint x;
         longint a1;
         longint a2;
         longint a3;
         longint d0;
         x  = s;
         a1 = newest;
         a2 = middle;
         a3 = oldest;
         samples_noted++;
         if (seen >= chu_pkg::SEEN_TWO) begin
            d0 = (seen == chu_pkg::SEEN_MAX) ? a1 - a3 : 0;
            push_interval(a2, a1, d0, x - a2, 1'b0);
         end
         if (!l) begin
            oldest = middle;
            middle = newest;
            newest = s;
            if (seen != chu_pkg::SEEN_MAX) seen = seen + 1'b1;
         end else begin
            if (seen >= chu_pkg::SEEN_TWO) begin
               push_interval(a1, x, x - a2, 0, 1'b0);
            end else if (seen == chu_pkg::SEEN_ONE) begin
               push_interval(a1, x, 0, 0, 1'b0);
            end
            push_interval(x, 0, 0, 0, 1'b1);
            newest = '0;
            middle = '0;
            oldest = '0;
            seen   = chu_pkg::SEEN_NONE;
            traces_closed++;
         end
      endfunction

      function void check_beat(logic signed [chu_pkg::SAMPLE_W-1:0] s, logic l);
         beat_type want;
         beats_checked++;
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: sample_out=%0d last_out=%0b", s, l);
            failures++;
         end else begin
            want = expected_beats.pop_front();
            if (want.sample !== s) begin
               $error("sample_out mismatch: expected %0d, actual %0d", want.sample, s);
               failures++;
            end
            if (want.last !== l) begin
               $error("last_out mismatch: expected %0b, actual %0b", want.last, l);
               failures++;
            end
         end
      endfunction
   endclass

   logic                                clock          = 1'b0;
   logic                                reset          = 1'b1;
   logic                                req_valid      = 1'b0;
   logic                                req_stall;
   logic signed [chu_pkg::SAMPLE_W-1:0] req_sample_in  = '0;
   logic                                req_last_in    = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall      = 1'b0;
   logic signed [chu_pkg::SAMPLE_W-1:0] rsp_sample_out;
   logic                                rsp_last_out;
   logic                                csr_wr_en      = 1'b0;
   logic [chu_pkg::CSR_W-1:0]           csr_wr_data    = chu_pkg::CSR_RESET;

   hermite_scoreboard sb;
   int                send_idle_pct = 0;
   int                stall_pct     = 0;

   cubic_hermite_upsampler #(
      .MAX_UPSAMPLE_LOG2(MAX_LOG2)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample_in (req_sample_in),
      .req_last_in   (req_last_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sample_out(rsp_sample_out),
      .rsp_last_out  (rsp_last_out),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_beat(rsp_sample_out, rsp_last_out);
      end
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic logic signed [chu_pkg::SAMPLE_W-1:0] pick_value();
      logic signed [chu_pkg::SAMPLE_W-1:0] v;
      case ($urandom_range(9))
         0: v = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         1: v = chu_pkg::SAMPLE_W'($urandom_range(64)) - chu_pkg::SAMPLE_W'(32);
         default: v = chu_pkg::SAMPLE_W'($urandom);
      endcase
      return v;
   endfunction

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_sample(logic signed [chu_pkg::SAMPLE_W-1:0] s, logic l);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      req_last_in   <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_sample(s, l);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_factor(logic [chu_pkg::CSR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.set_factor(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_directed();
      logic signed [chu_pkg::SAMPLE_W-1:0] vals [20] = '{
         16'sh7FFF,
         16'sh8000, 16'sh7FFF,
         16'sh7FFF, 16'sh8000, 16'sh7FFF,
         16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
         16'sh0000, 16'sh0001, 16'shFFFF, 16'sh5555, 16'shAAAA, 16'sh0000,
         16'sh3039, 16'shCFC7
      };
      logic ends [20] = '{
         1'b1,
         1'b0, 1'b1,
         1'b0, 1'b0, 1'b1,
         1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
         1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
         1'b0, 1'b0
      };
      for (int i = 0; i < 20; i++) begin
         send_sample(vals[i], ends[i]);
      end
   endtask

   // mostly complete traces of random content; the cutoff leaves a trace open
   task automatic run_random(int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(9))
            0, 1: len = $urandom_range(3, 1);
            2: len = $urandom_range(40, 16);
            default: len = $urandom_range(12, 4);
         endcase
         for (int j = 0; j < len && sent < n_items; j++) begin
            send_sample(pick_value(), j == len - 1);
            sent++;
         end
      end
   endtask

   initial begin
      logic [chu_pkg::CSR_W-1:0] factors [6];
      factors = '{3'd0, 3'd2, 3'd7, 3'd3, 3'd5, 3'd1};
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 22;
      stall_pct     = 45;
      write_factor(chu_pkg::CSR_W'(MAX_LOG2));
      run_directed();
      settle();

      for (int seg = 0; seg < 6; seg++) begin
         if (seg < 2) begin
            send_idle_pct = 22;
            stall_pct     = 45;
         end else if (seg < 4) begin
            send_idle_pct = 45;
            stall_pct     = 22;
         end else begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         write_factor(factors[seg]);
         run_random(58);
         settle();
      end

      $display("tb: %0d samples in %0d closed traces, %0d output beats checked",
               sb.samples_noted, sb.traces_closed, sb.beats_checked);
      $display("tb: factors 1 to 16 including out-of-range setting, with and without idling");
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[sim.f]
design/chu_pkg.sv
design/chu_ctrl.sv
design/chu_datapath.sv
design/cubic_hermite_upsampler.sv
tb/tb_cubic_hermite_upsampler.sv
